FILE: hdl/scba_pkg.sv
`default_nettype none

package scba_pkg;

  // Default geometry of the pool.
  localparam int unsigned SliceBytesLog2Def = 12;
  localparam int unsigned SliceCountDef     = 16;
  localparam int unsigned ClassCountDef     = 13;
  localparam int unsigned MinBlockBytesDef  = 8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pop_start;
    logic pop_finish;
    logic cut;
    logic claim;
    logic next_class;
    logic set_oom;
    logic free_push;
    logic free_bad;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic past_top;
    logic head_valid;
    logic can_cut;
    logic can_claim;
    logic free_ok;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: hdl/scba_req_if.sv
`default_nettype none

interface scba_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] request_size;
  logic [31:0] block_address;

  modport source (output valid, op, request_size, block_address, input ready);
  modport sink (input valid, op, request_size, block_address, output ready);
endinterface

`default_nettype wire

FILE: hdl/scba_rsp_if.sv
`default_nettype none

interface scba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [3:0]  size_class;
  logic [1:0]  status;

  modport source (output valid, granted_address, size_class, status, input ready);
  modport sink (input valid, granted_address, size_class, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/size_class_block_allocator.sv
`default_nettype none

// Channel  Dir  Payload                                   Transaction
// req_i    in   op, request_size, block_address           valid && ready
// rsp_o    out  granted_address, size_class, status       valid && ready
// cfg      in   cfg_wdata_i (pool_base)                   cfg_we_i
//
// A free passes through the check state (S_FREE) and the result state (S_RESP)
// before its result is loaded into the output register. An allocation steps up
// one size class at a time while classes are skipped for lack of slices, and a
// block popped from a free list takes the extra S_POP state (link memory read).
// The next request is accepted in the cycle after the result is loaded.
// Reset clears all class and slice state at once; the link memory is not cleared.
// A new request is taken while the previous result waits in the output register;
// a result that finds that register still full holds the controller and the input.

module size_class_block_allocator #(
  parameter int unsigned SliceBytesLog2 = scba_pkg::SliceBytesLog2Def,
  parameter int unsigned SliceCount     = scba_pkg::SliceCountDef,
  parameter int unsigned ClassCount     = scba_pkg::ClassCountDef,
  parameter int unsigned MinBlockBytes  = scba_pkg::MinBlockBytesDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  scba_req_if.sink    req_i,
  scba_rsp_if.source  rsp_o
);
  import scba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  scba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.op),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Allocator state and result path.
  scba_dp #(
    .SliceBytesLog2 (SliceBytesLog2),
    .SliceCount     (SliceCount),
    .ClassCount     (ClassCount),
    .MinBlockBytes  (MinBlockBytes)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .size_i      (req_i.request_size),
    .addr_i      (req_i.block_address),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .granted_o   (rsp_o.granted_address),
    .class_o     (rsp_o.size_class),
    .status_o    (rsp_o.status)
  );

`ifndef SYNTHESIS
  // A result is only loaded when the output register is free.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result loaded over an undelivered result");

  // One request is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while busy");

  // At most one state-changing action per cycle.
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.pop_start, cmd.cut, cmd.claim, cmd.next_class,
              cmd.set_oom, cmd.free_push, cmd.free_bad}))
    else $error("conflicting datapath actions");
`endif

endmodule

`default_nettype wire

FILE: hdl/scba_ctrl.sv
`default_nettype none

module scba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_op_i,
  output logic           req_ready_o,
  input  scba_pkg::stat_t stat_i,
  output scba_pkg::cmd_t  cmd_o
);
  import scba_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (req_op_i == OP_FREE) ? S_FREE : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (stat_i.past_top) begin
          cmd_o.set_oom = 1'b1;
          state_d       = S_RESP;
        end else if (stat_i.head_valid) begin
          cmd_o.pop_start = 1'b1;
          state_d         = S_POP;
        end else if (stat_i.can_cut) begin
          cmd_o.cut = 1'b1;
          state_d   = S_RESP;
        end else if (stat_i.can_claim) begin
          cmd_o.claim = 1'b1;
          state_d     = S_RESP;
        end else begin
          cmd_o.next_class = 1'b1;
        end
      end
      S_POP: begin
        cmd_o.pop_finish = 1'b1;
        state_d          = S_RESP;
      end
      S_FREE: begin
        if (stat_i.free_ok) begin
          cmd_o.free_push = 1'b1;
        end else begin
          cmd_o.free_bad = 1'b1;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/scba_dp.sv
`default_nettype none

module scba_dp #(
  parameter int unsigned SliceBytesLog2 = scba_pkg::SliceBytesLog2Def,
  parameter int unsigned SliceCount     = scba_pkg::SliceCountDef,
  parameter int unsigned ClassCount     = scba_pkg::ClassCountDef,
  parameter int unsigned MinBlockBytes  = scba_pkg::MinBlockBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  input  scba_pkg::cmd_t  cmd_i,
  output scba_pkg::stat_t stat_o,
  input  logic [31:0]     size_i,
  input  logic [31:0]     addr_i,
  input  logic            rsp_ready_i,
  output logic            rsp_valid_o,
  output logic [31:0]     granted_o,
  output logic [3:0]      class_o,
  output logic [1:0]      status_o
);
  import scba_pkg::*;

  localparam int unsigned UnitLog2 = $clog2(MinBlockBytes);
  localparam int unsigned TopClass =
      (ClassCount - 1 < SliceBytesLog2) ? ClassCount - 1 : SliceBytesLog2;
  localparam int unsigned ClsW   = $clog2(ClassCount + 1);
  localparam int unsigned CIdxW  = $clog2(ClassCount);
  localparam int unsigned SIdxW  = (SliceCount > 1) ? $clog2(SliceCount) : 1;
  localparam int unsigned SCntW  = $clog2(SliceCount + 1);
  localparam int unsigned OffW   = SliceBytesLog2 + 1;
  localparam int unsigned LinkDepth = SliceCount << (SliceBytesLog2 - UnitLog2);
  localparam int unsigned UnitW  = $clog2(LinkDepth);

  // Registers and per-class state.
  logic [31:0]       base_q;
  logic [ClsW-1:0]   cls_q;
  logic [31:0]       foff_q;
  logic [31:0]       res_addr_q;
  logic [ClsW-1:0]   res_cls_q;
  status_e           res_st_q;
  logic              head_vld_q  [ClassCount];
  logic [UnitW-1:0]  head_q      [ClassCount];
  logic              slice_vld_q [ClassCount];
  logic [SIdxW-1:0]  slice_q     [ClassCount];
  logic [OffW-1:0]   soff_q      [ClassCount];
  logic [ClsW-1:0]   owner_q     [SliceCount];
  logic [SCntW-1:0]  claimed_q;
  logic [UnitW:0]    link_mem    [LinkDepth];
  logic [UnitW:0]    link_rd_q;
  logic              out_vld_q;
  logic [31:0]       out_addr_q;
  logic [3:0]        out_cls_q;
  logic [1:0]        out_st_q;

  logic [ClsW-1:0]   cls_calc;
  logic              past_top;
  logic [CIdxW-1:0]  cidx;
  logic [OffW-1:0]   blk;
  logic [31:0]       cut_addr, claim_addr, pop_addr;
  logic [31:0]       fslice;
  logic              slice_in;
  logic [SIdxW-1:0]  sidx;
  logic [ClsW-1:0]   owner;
  logic [CIdxW-1:0]  oidx;
  logic              misal;
  logic              owner_ok;
  logic [UnitW-1:0]  unit;
  logic [ClsW+3:0]   res_cls_ext;

  // Size class of a request: count the block sizes the request exceeds.
  always_comb begin
    cls_calc = ClsW'(UnitLog2);
    for (int k = UnitLog2; k <= TopClass; k++) begin
      if ({1'b0, size_i} > (33'd1 << k)) cls_calc = ClsW'(k + 1);
    end
  end

  // Allocation view of the current class.
  assign past_top   = cls_q > ClsW'(TopClass);
  assign cidx       = past_top ? '0 : cls_q[CIdxW-1:0];
  assign blk        = OffW'(1) << cls_q;
  assign cut_addr   = base_q + (32'(slice_q[cidx]) << SliceBytesLog2) + 32'(soff_q[cidx]);
  assign claim_addr = base_q + (32'(claimed_q) << SliceBytesLog2);
  assign pop_addr   = base_q + (32'(head_q[cidx]) << UnitLog2);

  // Free checks on the latched pool offset.
  assign fslice   = foff_q >> SliceBytesLog2;
  assign slice_in = (fslice < 32'(SliceCount)) && (fslice < 32'(claimed_q));
  assign sidx     = foff_q[SliceBytesLog2 +: SIdxW];
  assign owner    = owner_q[sidx];
  assign oidx     = owner[CIdxW-1:0];
  assign owner_ok = (owner >= ClsW'(UnitLog2)) && (owner <= ClsW'(TopClass));
  assign unit     = foff_q[UnitLog2 +: UnitW];

  always_comb begin
    misal = 1'b0;
    for (int b = 0; b < SliceBytesLog2; b++) begin
      if ((ClsW'(b) < owner) && foff_q[b]) misal = 1'b1;
    end
  end

  always_comb begin
    stat_o.past_top   = past_top;
    stat_o.head_valid = head_vld_q[cidx];
    stat_o.can_cut    = slice_vld_q[cidx] && (soff_q[cidx] < (OffW'(1) << SliceBytesLog2));
    stat_o.can_claim  = claimed_q < SCntW'(SliceCount);
    stat_o.free_ok    = slice_in && owner_ok && !misal;
    stat_o.out_free   = !out_vld_q || rsp_ready_i;
  end

  // Link memory: written by frees, read by pops.
  always_ff @(posedge clk_i) begin
    if (cmd_i.free_push) begin
      link_mem[unit] <= {head_vld_q[oidx], head_q[oidx]};
    end
    if (cmd_i.pop_start) begin
      link_rd_q <= link_mem[head_q[cidx]];
    end
  end

  // Allocator state, pending result and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      cls_q      <= '0;
      foff_q     <= '0;
      res_addr_q <= '0;
      res_cls_q  <= '0;
      res_st_q   <= ST_OK;
      claimed_q  <= '0;
      out_vld_q  <= 1'b0;
      out_addr_q <= '0;
      out_cls_q  <= '0;
      out_st_q   <= '0;
      for (int i = 0; i < ClassCount; i++) begin
        head_vld_q[i]  <= 1'b0;
        head_q[i]      <= '0;
        slice_vld_q[i] <= 1'b0;
        slice_q[i]     <= '0;
        soff_q[i]      <= '0;
      end
      for (int i = 0; i < SliceCount; i++) begin
        owner_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        cls_q  <= cls_calc;
        foff_q <= addr_i - base_q;
      end
      if (cmd_i.next_class) begin
        cls_q <= cls_q + 1'b1;
      end
      if (cmd_i.pop_start) begin
        res_addr_q <= pop_addr;
        res_cls_q  <= cls_q;
        res_st_q   <= ST_OK;
      end
      if (cmd_i.pop_finish) begin
        head_vld_q[cidx] <= link_rd_q[UnitW];
        head_q[cidx]     <= link_rd_q[UnitW-1:0];
      end
      if (cmd_i.cut) begin
        soff_q[cidx] <= soff_q[cidx] + blk;
        res_addr_q   <= cut_addr;
        res_cls_q    <= cls_q;
        res_st_q     <= ST_OK;
      end
      if (cmd_i.claim) begin
        slice_vld_q[cidx]             <= 1'b1;
        slice_q[cidx]                 <= claimed_q[SIdxW-1:0];
        owner_q[claimed_q[SIdxW-1:0]] <= cls_q;
        soff_q[cidx]                  <= blk;
        claimed_q                     <= claimed_q + 1'b1;
        res_addr_q                    <= claim_addr;
        res_cls_q                     <= cls_q;
        res_st_q                      <= ST_OK;
      end
      if (cmd_i.set_oom) begin
        res_addr_q <= '0;
        res_cls_q  <= '0;
        res_st_q   <= ST_OOM;
      end
      if (cmd_i.free_push) begin
        head_vld_q[oidx] <= 1'b1;
        head_q[oidx]     <= unit;
        res_addr_q       <= '0;
        res_cls_q        <= owner;
        res_st_q         <= ST_OK;
      end
      if (cmd_i.free_bad) begin
        res_addr_q <= '0;
        res_cls_q  <= '0;
        res_st_q   <= ST_BAD_FREE;
      end
      if (cmd_i.emit) begin
        out_vld_q  <= 1'b1;
        out_addr_q <= res_addr_q;
        out_cls_q  <= res_cls_ext[3:0];
        out_st_q   <= res_st_q;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign res_cls_ext = {4'b0, res_cls_q};
  assign rsp_valid_o = out_vld_q;
  assign granted_o   = out_addr_q;
  assign class_o     = out_cls_q;
  assign status_o    = out_st_q;

endmodule

`default_nettype wire
